>>> rtl/tfn_pkg.sv
// Package for the triangle face normal unit.
// Holds the sequencer state type, the operation codes and the fixed field widths.
// Depends on nothing.
package tfn_pkg;

    localparam int IDX_W = 10;        // width of every vertex index field
    localparam int OUT_W = 16;        // width of a normal component (Q1.14)
    localparam int Q_BITS = 15;       // quotient bits, |unit| <= 2^14
    localparam int FRAC_SHIFT = 14;   // fraction bits of the result

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FACE = 1'b1;

    // Square-accumulate parts of one component: lo*lo, hi*lo (twice), hi*hi.
    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RED   = 10'b00_0000_0010,
        S_WR    = 10'b00_0000_0100,
        S_RD    = 10'b00_0000_1000,
        S_DIFF  = 10'b00_0001_0000,
        S_CROSS = 10'b00_0010_0000,
        S_SQ    = 10'b00_0100_0000,
        S_SQRT  = 10'b00_1000_0000,
        S_DIV   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

endpackage

>>> rtl/triangle_face_normal.sv
// Triangle face normal unit: vertex memory, cross product, integer square root
// and three restoring divisions around one shared multiplier. Uses tfn_pkg.
//
//   channel  signals                                      direction
//   in       in_valid/in_ready, op, vertex_index, coord_*, in
//            first_index, second_index, third_index
//   out      out_valid/out_ready, unit_x/y/z, degenerate    out
//
// A face word passes the bit-serial square root (2*COORD_WIDTH+3 steps) and
// 45 division steps; a face whose cross product is zero skips the divisions.
// If VERTEX_DEPTH is below 1024 and not a power of two, every word first
// passes through index reduction. Reset clears control only; vertex memory
// is undefined until written. A result waiting on out does not block input;
// only the next result stalls until the previous is taken.
module triangle_face_normal #(
    parameter int VERTEX_DEPTH = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [tfn_pkg::IDX_W-1:0]     vertex_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic [tfn_pkg::IDX_W-1:0]     first_index,
    input  logic [tfn_pkg::IDX_W-1:0]     second_index,
    input  logic [tfn_pkg::IDX_W-1:0]     third_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [tfn_pkg::OUT_W-1:0] unit_x,
    output logic signed [tfn_pkg::OUT_W-1:0] unit_y,
    output logic signed [tfn_pkg::OUT_W-1:0] unit_z,
    output logic                          degenerate
);

    localparam int W = COORD_WIDTH;
    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int EW = (AW > tfn_pkg::IDX_W) ? AW : tfn_pkg::IDX_W;
    localparam int RDW = AW + tfn_pkg::IDX_W;
    localparam bit RED_NEEDED = (VERTEX_DEPTH < (1 << tfn_pkg::IDX_W)) &&
                                ((VERTEX_DEPTH & (VERTEX_DEPTH - 1)) != 0);
    localparam int DW = W + 1;          // coordinate difference
    localparam int MW = W + 2;          // multiplier operand
    localparam int ASW = 2 * W + 3;     // signed cross product component
    localparam int H = W + 1;           // half of a magnitude
    localparam int AMW = 2 * H;         // cross product magnitude
    localparam int SW = 2 * AMW + 2;    // sum of squares
    localparam int RW = SW / 2;         // square root
    localparam int CNTW = $clog2(RW);

    tfn_pkg::state_t state_reg, state_next;

    logic [CNTW-1:0]              cnt_reg;
    logic                         op_reg;
    logic [tfn_pkg::IDX_W-1:0]    idx_reg [4];
    logic [EW-1:0]                idx_ext [4];
    logic signed [W-1:0]          cx_reg, cy_reg, cz_reg;
    logic signed [W-1:0]          v_reg [3][3];
    logic signed [DW-1:0]         b_reg [3];
    logic signed [DW-1:0]         c_reg [3];
    logic signed [ASW-1:0]        a_reg [3];
    logic [AMW-1:0]               a_mag [3];
    logic signed [MW-1:0]         mul_a, mul_b;
    logic signed [2*MW-1:0]       prod_reg;
    logic [1:0]                   comp_reg, part_reg, pend_part_reg;
    logic                         issue_reg, pend_valid_reg;
    logic [SW-1:0]                s_reg;
    logic [RW-1:0]                root_reg, root_next;
    logic [RW+1:0]                sq_rem_reg, rem_sh, rem_next, trial;
    logic                         sq_ge;
    logic [RW:0]                  div_rem_reg;
    logic                         div_ge;
    logic [RW:0]                  div_diff;
    logic [tfn_pkg::Q_BITS-1:0]   q_acc_reg, q_bits;
    logic [tfn_pkg::OUT_W-1:0]    q_u, q_s;
    logic signed [tfn_pkg::OUT_W-1:0] q_reg [3];
    logic                         degen_reg;
    logic                         out_valid_reg;
    logic [AW-1:0]                raddr, waddr;
    logic [3*W-1:0]               rd_data_reg;
    logic [3*W-1:0]               mem [VERTEX_DEPTH];
    logic [RDW-1:0]               red_sub;
    logic [SW-1:0]                prod_ext;
    logic                         in_fire;

    assign in_ready = (state_reg == tfn_pkg::S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            idx_ext[l] = EW'(idx_reg[l]);
        end
        for (int i = 0; i < 3; i++)
        begin
            a_mag[i] = a_reg[i][ASW-1] ? AMW'(-a_reg[i]) : AMW'(a_reg[i]);
        end
    end

    assign waddr = idx_ext[0][AW-1:0];

    always_comb
    begin
        case (cnt_reg)
            CNTW'(0): raddr = idx_ext[1][AW-1:0];
            CNTW'(1): raddr = idx_ext[2][AW-1:0];
            default:  raddr = idx_ext[3][AW-1:0];
        endcase
    end

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (state_reg == tfn_pkg::S_WR)
        begin
            mem[waddr] <= {cz_reg, cy_reg, cx_reg};
        end
        rd_data_reg <= mem[raddr];
    end

    assign red_sub = RDW'(VERTEX_DEPTH) << cnt_reg;

    // Shared multiplier operands: cross-product terms, then magnitude halves.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == tfn_pkg::S_CROSS)
        begin
            case (cnt_reg)
                CNTW'(0): begin mul_a = MW'(c_reg[1]); mul_b = MW'(b_reg[2]); end
                CNTW'(1): begin mul_a = MW'(c_reg[2]); mul_b = MW'(b_reg[1]); end
                CNTW'(2): begin mul_a = MW'(c_reg[2]); mul_b = MW'(b_reg[0]); end
                CNTW'(3): begin mul_a = MW'(c_reg[0]); mul_b = MW'(b_reg[2]); end
                CNTW'(4): begin mul_a = MW'(c_reg[0]); mul_b = MW'(b_reg[1]); end
                default:  begin mul_a = MW'(c_reg[1]); mul_b = MW'(b_reg[0]); end
            endcase
        end
        else
        begin
            case (part_reg)
                tfn_pkg::PART_LL:
                begin
                    mul_a = {1'b0, a_mag[comp_reg][H-1:0]};
                    mul_b = {1'b0, a_mag[comp_reg][H-1:0]};
                end
                tfn_pkg::PART_HL:
                begin
                    mul_a = {1'b0, a_mag[comp_reg][AMW-1:H]};
                    mul_b = {1'b0, a_mag[comp_reg][H-1:0]};
                end
                default:
                begin
                    mul_a = {1'b0, a_mag[comp_reg][AMW-1:H]};
                    mul_b = {1'b0, a_mag[comp_reg][AMW-1:H]};
                end
            endcase
        end
    end

    always_comb
    begin
        prod_ext = SW'(prod_reg[AMW-1:0]);
        case (pend_part_reg)
            tfn_pkg::PART_LL: prod_ext = SW'(prod_reg[AMW-1:0]);
            tfn_pkg::PART_HL: prod_ext = SW'(prod_reg[AMW-1:0]) << (H + 1);
            default:          prod_ext = SW'(prod_reg[AMW-1:0]) << (2 * H);
        endcase
    end

    // One root bit per step.
    always_comb
    begin
        rem_sh = {sq_rem_reg[RW-1:0], s_reg[SW-1:SW-2]};
        trial = {root_reg, 2'b01};
        sq_ge = (rem_sh >= trial);
        rem_next = sq_ge ? (rem_sh - trial) : rem_sh;
        root_next = {root_reg[RW-2:0], sq_ge};
    end

    // One quotient bit per step.
    always_comb
    begin
        div_ge = (div_rem_reg >= {1'b0, root_reg});
        div_diff = div_ge ? (div_rem_reg - {1'b0, root_reg}) : div_rem_reg;
        q_bits = {q_acc_reg[tfn_pkg::Q_BITS-2:0], div_ge};
        q_u = tfn_pkg::OUT_W'(q_bits);
        q_s = a_reg[comp_reg][ASW-1] ? (-q_u) : q_u;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tfn_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (RED_NEEDED)
                        state_next = tfn_pkg::S_RED;
                    else if (op == tfn_pkg::OP_FACE)
                        state_next = tfn_pkg::S_RD;
                    else
                        state_next = tfn_pkg::S_WR;
                end
            end
            tfn_pkg::S_RED:
            begin
                if (cnt_reg == '0)
                    state_next = (op_reg == tfn_pkg::OP_FACE) ? tfn_pkg::S_RD : tfn_pkg::S_WR;
            end
            tfn_pkg::S_WR:    state_next = tfn_pkg::S_IDLE;
            tfn_pkg::S_RD:    if (cnt_reg == CNTW'(3)) state_next = tfn_pkg::S_DIFF;
            tfn_pkg::S_DIFF:  state_next = tfn_pkg::S_CROSS;
            tfn_pkg::S_CROSS: if (cnt_reg == CNTW'(6)) state_next = tfn_pkg::S_SQ;
            tfn_pkg::S_SQ:    if (pend_valid_reg && !issue_reg) state_next = tfn_pkg::S_SQRT;
            tfn_pkg::S_SQRT:
            begin
                if (cnt_reg == '0)
                    state_next = (root_next == '0) ? tfn_pkg::S_DONE : tfn_pkg::S_DIV;
            end
            tfn_pkg::S_DIV:
            begin
                if (cnt_reg == '0 && comp_reg == 2'd2)
                    state_next = tfn_pkg::S_DONE;
            end
            tfn_pkg::S_DONE:  if (!out_valid_reg || out_ready) state_next = tfn_pkg::S_IDLE;
            default:          state_next = tfn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tfn_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            issue_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == tfn_pkg::S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                tfn_pkg::S_IDLE:
                    cnt_reg <= RED_NEEDED ? CNTW'(tfn_pkg::IDX_W - 1) : '0;
                tfn_pkg::S_RED:
                    cnt_reg <= (cnt_reg == '0) ? '0 : cnt_reg - CNTW'(1);
                tfn_pkg::S_RD, tfn_pkg::S_CROSS:
                    cnt_reg <= (state_next == state_reg) ? cnt_reg + CNTW'(1) : '0;
                tfn_pkg::S_DIFF:
                    cnt_reg <= '0;
                tfn_pkg::S_SQ:
                    cnt_reg <= CNTW'(RW - 1);
                tfn_pkg::S_SQRT, tfn_pkg::S_DIV:
                    cnt_reg <= (cnt_reg == '0) ? CNTW'(tfn_pkg::Q_BITS - 1) : cnt_reg - CNTW'(1);
                default:
                    cnt_reg <= cnt_reg;
            endcase

            if (state_reg == tfn_pkg::S_CROSS && cnt_reg == CNTW'(6))
                issue_reg <= 1'b1;
            else if (state_reg == tfn_pkg::S_SQ && comp_reg == 2'd2 &&
                     part_reg == tfn_pkg::PART_HH)
                issue_reg <= 1'b0;
            pend_valid_reg <= (state_reg == tfn_pkg::S_SQ) && issue_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tfn_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg <= op;
                    idx_reg[0] <= vertex_index;
                    idx_reg[1] <= first_index;
                    idx_reg[2] <= second_index;
                    idx_reg[3] <= third_index;
                    cx_reg <= coord_x;
                    cy_reg <= coord_y;
                    cz_reg <= coord_z;
                end
            end
            tfn_pkg::S_RED:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (RDW'(idx_reg[l]) >= red_sub)
                        idx_reg[l] <= tfn_pkg::IDX_W'(RDW'(idx_reg[l]) - red_sub);
                end
            end
            tfn_pkg::S_RD:
            begin
                if (cnt_reg != '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        v_reg[2'(cnt_reg - CNTW'(1))][k] <= rd_data_reg[k*W +: W];
                    end
                end
            end
            tfn_pkg::S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_reg[k] <= DW'(v_reg[1][k]) - DW'(v_reg[0][k]);
                    c_reg[k] <= DW'(v_reg[1][k]) - DW'(v_reg[2][k]);
                end
            end
            tfn_pkg::S_CROSS:
            begin
                prod_reg <= mul_a * mul_b;
                // Accumulate the product issued in the previous cycle.
                if (cnt_reg != '0)
                begin
                    if (cnt_reg[0])
                        a_reg[2'((cnt_reg - CNTW'(1)) >> 1)] <= prod_reg[ASW-1:0];
                    else
                        a_reg[2'((cnt_reg - CNTW'(1)) >> 1)] <=
                            a_reg[2'((cnt_reg - CNTW'(1)) >> 1)] - prod_reg[ASW-1:0];
                end
                comp_reg <= 2'd0;
                part_reg <= tfn_pkg::PART_LL;
                s_reg <= '0;
            end
            tfn_pkg::S_SQ:
            begin
                prod_reg <= mul_a * mul_b;
                pend_part_reg <= part_reg;
                if (issue_reg)
                begin
                    if (part_reg == tfn_pkg::PART_HH)
                    begin
                        part_reg <= tfn_pkg::PART_LL;
                        comp_reg <= comp_reg + 2'd1;
                    end
                    else
                    begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
                if (pend_valid_reg)
                    s_reg <= s_reg + prod_ext;
                sq_rem_reg <= '0;
                root_reg <= '0;
            end
            tfn_pkg::S_SQRT:
            begin
                s_reg <= s_reg << 2;
                sq_rem_reg <= rem_next;
                root_reg <= root_next;
                degen_reg <= (root_next == '0);
                comp_reg <= 2'd0;
                div_rem_reg <= (RW + 1)'(a_mag[0]);
                for (int i = 0; i < 3; i++)
                begin
                    q_reg[i] <= '0;
                end
            end
            tfn_pkg::S_DIV:
            begin
                q_acc_reg <= q_bits;
                if (cnt_reg == '0)
                begin
                    q_reg[comp_reg] <= q_s;
                end
                if (cnt_reg == '0 && comp_reg != 2'd2)
                begin
                    comp_reg <= comp_reg + 2'd1;
                    div_rem_reg <= (RW + 1)'(a_mag[comp_reg + 2'd1]);
                end
                else
                begin
                    div_rem_reg <= {div_diff[RW-1:0], 1'b0};
                end
            end
            tfn_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    unit_x <= q_reg[0];
                    unit_y <= q_reg[1];
                    unit_z <= q_reg[2];
                    degenerate <= degen_reg;
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

endmodule

>>> test/triangle_face_normal_checker.sv
// Checker for the triangle face normal unit: watches the input and output
// channels, predicts each face normal from its own vertex memory and compares.
// Depends on tfn_pkg.
module triangle_face_normal_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          op,
    input  logic [tfn_pkg::IDX_W-1:0]     vertex_index,
    input  logic signed [15:0]            coord_x,
    input  logic signed [15:0]            coord_y,
    input  logic signed [15:0]            coord_z,
    input  logic [tfn_pkg::IDX_W-1:0]     first_index,
    input  logic [tfn_pkg::IDX_W-1:0]     second_index,
    input  logic [tfn_pkg::IDX_W-1:0]     third_index,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [15:0]            unit_x,
    input  logic signed [15:0]            unit_y,
    input  logic signed [15:0]            unit_z,
    input  logic                          degenerate,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               degen;
    } normal_t;

    logic signed [15:0] mem_x [1024];
    logic signed [15:0] mem_y [1024];
    logic signed [15:0] mem_z [1024];
    normal_t expected_normals[$];

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int bitpos = 63; bitpos >= 0; bitpos--)
        begin
            cand = r | (64'd1 << bitpos);
            if ({64'd0, cand} * {64'd0, cand} <= s)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] scale(input longint a, input logic [63:0] n);
        longint unsigned m;
        longint unsigned q;
        m = (a < 0) ? -a : a;
        q = (m << tfn_pkg::FRAC_SHIFT) / n;
        if (a < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic normal_t face_normal(input logic [9:0] i0, input logic [9:0] i1,
                                           input logic [9:0] i2);
        longint bx, by, bz, cx, cy, cz, ax, ay, az;
        logic [127:0] mx, my, mz;
        logic [127:0] s;
        logic [63:0] n;
        normal_t r;
        bx = longint'(mem_x[i1]) - longint'(mem_x[i0]);
        by = longint'(mem_y[i1]) - longint'(mem_y[i0]);
        bz = longint'(mem_z[i1]) - longint'(mem_z[i0]);
        cx = longint'(mem_x[i1]) - longint'(mem_x[i2]);
        cy = longint'(mem_y[i1]) - longint'(mem_y[i2]);
        cz = longint'(mem_z[i1]) - longint'(mem_z[i2]);
        ax = cy * bz - cz * by;
        ay = cz * bx - cx * bz;
        az = cx * by - cy * bx;
        // Each component fits in 34 bits; square the magnitudes in 128 bits.
        mx = 128'((ax < 0) ? -ax : ax);
        my = 128'((ay < 0) ? -ay : ay);
        mz = 128'((az < 0) ? -az : az);
        s = mx * mx + my * my + mz * mz;
        n = isqrt(s);
        if (n == 0)
            r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        else
            r = '{scale(ax, n), scale(ay, n), scale(az, n), 1'b0};
        return r;
    endfunction

    always @(posedge clk)
    begin
        normal_t e;
        if (rst_n && in_valid && in_ready)
        begin
            if (op == tfn_pkg::OP_WRITE)
            begin
                mem_x[vertex_index] <= coord_x;
                mem_y[vertex_index] <= coord_y;
                mem_z[vertex_index] <= coord_z;
            end
            else
                expected_normals.insert(expected_normals.size(),
                                        face_normal(first_index, second_index, third_index));
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_normals.size() == 0)
            begin
                fail_count <= fail_count + 1;
                if (fail_count < 10)
                    $display("ERROR: unexpected word %0d %0d %0d %0d",
                             unit_x, unit_y, unit_z, degenerate);
            end
            else
            begin
                e = expected_normals.pop_front();
                if (e.ux !== unit_x || e.uy !== unit_y || e.uz !== unit_z
                    || e.degen !== degenerate)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("ERROR: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 e.ux, e.uy, e.uz, e.degen,
                                 unit_x, unit_y, unit_z, degenerate);
                end
            end
        end
        pending <= expected_normals.size();
    end

endmodule

>>> test/triangle_face_normal_tb.sv
// Testbench top for the triangle face normal unit: drives vertex writes and
// face words with random idling and gives the verdict.
// Depends on tfn_pkg, triangle_face_normal and triangle_face_normal_checker.
module triangle_face_normal_tb;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic op;
    logic [tfn_pkg::IDX_W-1:0] vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [tfn_pkg::IDX_W-1:0] first_index;
    logic [tfn_pkg::IDX_W-1:0] second_index;
    logic [tfn_pkg::IDX_W-1:0] third_index;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic degenerate;
    int fail_count;
    int pending;
    bit calm;
    bit written [1024];
    logic [9:0] known[$];

    triangle_face_normal i_dut (.*);

    triangle_face_normal_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

    // The output side stalls at random except during the calm stretch.
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 21);

    task automatic send(input logic o, input logic [9:0] vi, input logic [15:0] x,
                        input logic [15:0] y, input logic [15:0] z, input logic [9:0] f0,
                        input logic [9:0] f1, input logic [9:0] f2);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        vertex_index <= vi;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        first_index <= f0;
        second_index <= f1;
        third_index <= f2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == tfn_pkg::OP_WRITE && !written[vi])
        begin
            written[vi] = 1;
            known.insert(known.size(), vi);
        end
    endtask

    task automatic write_vertex(input logic [9:0] vi, input logic [15:0] x,
                                input logic [15:0] y, input logic [15:0] z);
        send(tfn_pkg::OP_WRITE, vi, x, y, z, 10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic face(input logic [9:0] f0, input logic [9:0] f1, input logic [9:0] f2);
        send(tfn_pkg::OP_FACE, 10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             f0, f1, f2);
    endtask

    function automatic logic [9:0] pick_known();
        return known[$urandom_range(known.size() - 1)];
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return 16'($signed($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int wait_cycles;
        calm = 0;
        rst_n = 0;
        in_valid = 0;
        op = tfn_pkg::OP_WRITE;
        vertex_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        first_index = '0;
        second_index = '0;
        third_index = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, a right-angle triangle, degenerate faces.
        write_vertex(0, 16'h0000, 16'h0000, 16'h0000);
        write_vertex(1, 16'h0800, 16'h0000, 16'h0000);
        write_vertex(2, 16'h0000, 16'h0800, 16'h0000);
        write_vertex(1023, 16'h7fff, 16'h8000, 16'h7fff);
        write_vertex(512, 16'h8000, 16'h7fff, 16'h8000);
        write_vertex(3, 16'h8000, 16'h8000, 16'h8000);
        write_vertex(4, 16'h7fff, 16'h7fff, 16'h7fff);
        face(0, 1, 2);
        face(2, 1, 0);
        face(0, 0, 0);
        face(1023, 512, 0);
        face(3, 4, 0);
        face(3, 4, 1023);
        face(1023, 3, 512);
        face(1, 1, 2);
        write_vertex(5, 16'h1000, 16'h0000, 16'h0000);
        face(0, 1, 5);
        face(512, 1023, 4);

        for (int n = 0; n < 900; n++)
        begin
            calm = (n >= 300 && n < 450);
            if ($urandom_range(99) < 40)
                write_vertex(10'($urandom), rand_coord(), rand_coord(), rand_coord());
            else
                face(pick_known(), pick_known(),
                     $urandom_range(9) == 0 ? pick_known() : pick_known());
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        @(posedge clk);
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/tfn_pkg.sv
rtl/triangle_face_normal.sv
test/triangle_face_normal_checker.sv
test/triangle_face_normal_tb.sv
